/* rtl/lml_pkg.sv */
// ----------------------------------------------------------------------------
// lml_pkg
// Shared types, constants and character-class functions for the longest-match
// lexer: word layouts, token classes, scanner modes and the keyword table.
// ----------------------------------------------------------------------------
package lml_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int LEN_W          = (POSITION_WIDTH < 16) ? POSITION_WIDTH : 16;
    localparam int KW_COUNT       = 9;

    typedef enum logic [2:0] {
        CLS_OP      = 3'd0,
        CLS_DELIM   = 3'd1,
        CLS_KEYWORD = 3'd2,
        CLS_IDENT   = 3'd3,
        CLS_NUMBER  = 3'd4,
        CLS_UNKNOWN = 3'd5
    } cls_t;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_IDENT = 5'b00010,
        MODE_INT   = 5'b00100,
        MODE_DOT   = 5'b01000,
        MODE_FRAC  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        cls_t        token_class;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  single_byte;
        logic        last_of_run;
    } res_word_t;

    // Results of one scan step: up to three tokens, in order
    typedef struct packed {
        logic [1:0]      count;
        res_word_t [2:0] tok;
    } step_t;

    // Keywords, left-aligned: first character in bits [63:56]
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"int",      40'd0},
        {"float",    24'd0},
        {"if",       48'd0},
        {"else",     32'd0},
        {"while",    24'd0},
        {"for",      40'd0},
        {"break",    24'd0},
        {"continue"       },
        {"return",   16'd0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6
    };

    function automatic logic is_letter(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D
            || b == 8'h0C || b == 8'h0B;
    endfunction

    function automatic logic is_op(logic [7:0] b);
        return b == "+" || b == "-" || b == "*" || b == "/" || b == "="
            || b == "<" || b == ">" || b == "!" || b == "&" || b == "|"
            || b == "%";
    endfunction

    function automatic logic is_delim(logic [7:0] b);
        return b == "(" || b == ")" || b == "{" || b == "}" || b == "["
            || b == "]" || b == "," || b == ";" || b == ":";
    endfunction

    // Drop every keyword no longer than len or whose character at offset len differs from b
    function automatic logic [KW_COUNT-1:0] kw_next(logic [KW_COUNT-1:0] alive,
                                                  logic [LEN_W-1:0] len,
                                                  logic [7:0] b);
        logic [KW_COUNT-1:0] r;
        logic [2:0]          idx;
        r   = '0;
        idx = len[2:0];
        for (int k = 0; k < KW_COUNT; k++) begin
            r[k] = alive[k] && (len < LEN_W'(KW_LEN[k]))
                && (KW_TEXT[k][63 - 8 * idx -: 8] == b);
        end
        return r;
    endfunction

    function automatic logic kw_hit(logic [KW_COUNT-1:0] alive, logic [LEN_W-1:0] len);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (alive[k] && len == LEN_W'(KW_LEN[k])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Saturating add of a small increment
    function automatic logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] a, logic [1:0] inc);
        logic [LEN_W:0] s;
        s = {1'b0, a} + (LEN_W + 1)'(inc);
        return s[LEN_W] ? '1 : s[LEN_W-1:0];
    endfunction

    function automatic res_word_t make_token(cls_t c, logic [15:0] start,
                                             logic [15:0] len, logic [7:0] b);
        res_word_t t;
        t.token_class  = c;
        t.token_start  = start;
        t.token_length = len;
        t.single_byte  = (len == 16'd1) ? b : 8'd0;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

/* rtl/lml_scan.sv */
// ----------------------------------------------------------------------------
// lml_scan
// Input register and scanner state. Each step classifies one text byte,
// advances the scanner and produces up to three tokens.
// ----------------------------------------------------------------------------
module lml_scan
    import lml_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_payload,
    input  logic     q_ready,
    output logic     step_valid,
    output step_t    step
);

    logic                      in_valid_reg;
    in_word_t                  in_word_reg;

    mode_t                     mode_reg,  mode_next;
    logic [POSITION_WIDTH-1:0] pos_reg,   pos_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_next;
    logic [LEN_W-1:0]          len_reg,   len_next;
    logic [KW_COUNT-1:0]       alive_reg, alive_next;
    logic [7:0]                pbyte_reg, pbyte_next;

    logic                      fire;
    logic                      fresh;
    logic [7:0]                b;
    logic [1:0]                n;
    res_word_t [2:0]           tok;

    assign fire       = in_valid_reg && q_ready;
    assign s_ready    = !in_valid_reg || q_ready;
    assign step_valid = fire;
    assign step.count = n;
    assign step.tok   = tok;
    assign b          = in_word_reg.text_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            alive_reg <= '1;
            pbyte_reg <= '0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            alive_reg <= alive_next;
            pbyte_reg <= pbyte_next;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        alive_next = alive_reg;
        pbyte_next = pbyte_reg;
        n          = 2'd0;
        tok        = '0;
        fresh      = 1'b0;

        // Extend or close the pending token
        unique case (mode_reg)
            MODE_IDENT: begin
                if (is_letter(b) || is_digit(b) || b == "_") begin
                    alive_next = kw_next(alive_reg, len_reg, b);
                    len_next   = sat_add(len_reg, 2'd1);
                end else begin
                    tok[n] = make_token(kw_hit(alive_reg, len_reg) ? CLS_KEYWORD : CLS_IDENT,
                                        16'(start_reg), 16'(len_reg), pbyte_reg);
                    n      = n + 2'd1;
                    fresh  = 1'b1;
                end
            end
            MODE_INT: begin
                if (is_digit(b)) begin
                    len_next = sat_add(len_reg, 2'd1);
                end else if (b == ".") begin
                    mode_next = MODE_DOT;
                end else begin
                    tok[n] = make_token(CLS_NUMBER, 16'(start_reg), 16'(len_reg), pbyte_reg);
                    n      = n + 2'd1;
                    fresh  = 1'b1;
                end
            end
            MODE_DOT: begin
                if (is_digit(b)) begin
                    len_next  = sat_add(len_reg, 2'd2);
                    mode_next = MODE_FRAC;
                end else begin
                    // Give the held-back dot back as its own token
                    tok[n] = make_token(CLS_NUMBER, 16'(start_reg), 16'(len_reg), pbyte_reg);
                    n      = n + 2'd1;
                    tok[n] = make_token(CLS_UNKNOWN, 16'(pos_reg - POSITION_WIDTH'(1)),
                                        16'd1, ".");
                    n      = n + 2'd1;
                    fresh  = 1'b1;
                end
            end
            MODE_FRAC: begin
                if (is_digit(b)) begin
                    len_next = sat_add(len_reg, 2'd1);
                end else begin
                    tok[n] = make_token(CLS_NUMBER, 16'(start_reg), 16'(len_reg), pbyte_reg);
                    n      = n + 2'd1;
                    fresh  = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // Scan the byte afresh
        if (fresh) begin
            mode_next  = MODE_IDLE;
            len_next   = '0;
            alive_next = '1;
            if (is_space(b)) begin
                mode_next = MODE_IDLE;
            end else if (is_op(b)) begin
                tok[n] = make_token(CLS_OP, 16'(pos_reg), 16'd1, b);
                n      = n + 2'd1;
            end else if (is_delim(b)) begin
                tok[n] = make_token(CLS_DELIM, 16'(pos_reg), 16'd1, b);
                n      = n + 2'd1;
            end else if (is_letter(b) || b == "_") begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                pbyte_next = b;
                alive_next = kw_next('1, '0, b);
                len_next   = LEN_W'(1);
            end else if (is_digit(b)) begin
                mode_next  = MODE_INT;
                start_next = pos_reg;
                pbyte_next = b;
                len_next   = LEN_W'(1);
            end else begin
                tok[n] = make_token(CLS_UNKNOWN, 16'(pos_reg), 16'd1, b);
                n      = n + 2'd1;
            end
        end

        // Flush on the final byte and restart offsets; drop a fourth token
        if (in_word_reg.last_byte) begin
            unique case (mode_next)
                MODE_IDENT: begin
                    if (n != 2'd3) begin
                        tok[n] = make_token(kw_hit(alive_next, len_next) ? CLS_KEYWORD
                                                                         : CLS_IDENT,
                                            16'(start_next), 16'(len_next), pbyte_next);
                        n      = n + 2'd1;
                    end
                end
                MODE_INT, MODE_FRAC: begin
                    if (n != 2'd3) begin
                        tok[n] = make_token(CLS_NUMBER, 16'(start_next), 16'(len_next),
                                            pbyte_next);
                        n      = n + 2'd1;
                    end
                end
                MODE_DOT: begin
                    tok[n] = make_token(CLS_NUMBER, 16'(start_next), 16'(len_next), pbyte_next);
                    n      = n + 2'd1;
                    tok[n] = make_token(CLS_UNKNOWN, 16'(pos_reg), 16'd1, ".");
                    n      = n + 2'd1;
                end
                default: begin
                    n = n;
                end
            endcase
            mode_next  = MODE_IDLE;
            len_next   = '0;
            alive_next = '1;
            pos_next   = '0;
        end else begin
            pos_next   = pos_reg + POSITION_WIDTH'(1);
        end

        for (int i = 0; i < 3; i++) begin
            tok[i].last_of_run = (n != 2'd0) && (2'(i) == n - 2'd1);
        end
    end

endmodule

/* rtl/lml_outq.sv */
// ----------------------------------------------------------------------------
// lml_outq
// Result buffer for the tokens of one step. Loads a whole step when it will
// be empty by the end of the cycle and hands out one word per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module lml_outq
    import lml_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_valid,
    input  step_t     step,
    output logic      q_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output res_word_t m_payload
);

    res_word_t [2:0] ent_reg;
    logic [1:0]      count_reg;
    logic            pop;

    assign m_valid   = count_reg != 2'd0;
    assign m_payload = ent_reg[0];
    assign pop       = m_valid && m_ready;
    assign q_ready   = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (step_valid) begin
            count_reg <= step.count;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_valid) begin
            ent_reg <= step.tok;
        end else if (pop) begin
            // advance the remaining tokens towards the head
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

endmodule

/* rtl/longest_match_lexer_core.sv */
// ----------------------------------------------------------------------------
// longest_match_lexer_core
// Streaming longest-match tokenizer: one text byte per word in, one token per
// word out (operator, delimiter, keyword, identifier, number, unknown).
//
//   channel  dir  word        handshake
//   s_       in   in_word_t   s_valid / s_ready
//   m_       out  res_word_t  m_valid / m_ready
//
// A byte passes through an input register and one combinational scan step
// into a three-entry result buffer. A byte giving at most one token sustains
// one byte per cycle while m_ready is high; a byte giving more tokens stalls
// the input until the buffer is down to its last token and m_ready is high.
// Reset (aresetn low at a clock edge) clears the scanner and empties the buffer.
// A stalled m_ready backs up into s_ready through the buffer and input register.
// ----------------------------------------------------------------------------
module longest_match_lexer_core
    import lml_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output res_word_t m_payload
);

    logic  q_ready;
    logic  step_valid;
    step_t step;

    lml_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .q_ready    (q_ready),
        .step_valid (step_valid),
        .step       (step)
    );

    lml_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (step_valid),
        .step       (step),
        .q_ready    (q_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

    // Tokens of one byte leave without a gap
    a_run_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_payload.last_of_run |=> m_valid)
        else $error("token run broken before its last word");

    a_single_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.token_length != 16'd1 |-> m_payload.single_byte == 8'd0)
        else $error("single_byte set on a multi-byte token");

    a_keyword_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.token_class == CLS_KEYWORD
            |-> m_payload.token_length >= 16'd2 && m_payload.token_length <= 16'd8)
        else $error("keyword with impossible length");

    a_step_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        step_valid |-> !m_valid || (m_ready && m_payload.last_of_run))
        else $error("step loaded over undelivered tokens");

endmodule
